// ===== sv/hvd_pkg.sv =====
// shared constants, widths and arctangent table for the haversine distance block
`default_nettype none
package hvd_pkg;

  localparam int CORDIC_STAGES_DEF = 24;

  localparam int ANG_W = 32;
  localparam int XY_W  = 35;
  localparam int Z_W   = 34;
  localparam int Q31_W = 32;
  localparam int SQ_W  = 63;
  localparam int SQ_STEPS = 32;
  localparam int RT_W  = 32;
  localparam int VXY_W = 34;
  localparam int VZ_W  = 34;
  localparam int MAG_W = 39;

  localparam logic signed [XY_W-1:0] INV_GAIN = 35'sd2608131496;
  localparam logic signed [Q31_W-1:0] Q31_MAX = 32'sd2147483647;

  // reciprocal of 45 scaled by 2^45, rounded up
  localparam logic [39:0] RECIP_45 = 40'd781874935308;
  localparam logic [19:0] RECIP_LO = RECIP_45[19:0];
  localparam logic [19:0] RECIP_HI = RECIP_45[39:20];
  localparam int RECIP_SHIFT = 45;

  localparam logic [SQ_W-1:0] ONE_Q62 = {1'b1, 62'd0};
  localparam logic [VZ_W-1:0] QUARTER_TURN = 34'd1073741824;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned RADIUS_KM = 64'd6371;
  localparam longint unsigned DIST_MULT = (2 * RADIUS_KM * PI_Q30 + 64'd4096) >> 13;
  // distance multiplier is 2^32 plus this low part
  localparam logic [29:0] DIST_MULT_LO = DIST_MULT[29:0];
  localparam logic [30:0] HALF_DIST = 31'((RADIUS_KM * PI_Q30 + 64'd8192) >> 14);

  // atan(2^-i) in binary angle units, 2^32 per turn
  function automatic logic [ANG_W-1:0] atan_val(input logic [4:0] idx);
    logic [ANG_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      5'd31: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/hvd_rot_cell.sv =====
// one rotation-mode cordic stage for sine and cosine
`default_nettype none
module hvd_rot_cell #(
  parameter int SHIFT = 0
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [hvd_pkg::XY_W-1:0]  x_i,
  input  logic signed [hvd_pkg::XY_W-1:0]  y_i,
  input  logic signed [hvd_pkg::Z_W-1:0]   z_i,
  input  logic                             flip_i,
  output logic signed [hvd_pkg::XY_W-1:0]  x_o,
  output logic signed [hvd_pkg::XY_W-1:0]  y_o,
  output logic signed [hvd_pkg::Z_W-1:0]   z_o,
  output logic                             flip_o
);
  import hvd_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = signed'(Z_W'(atan_val(5'(SHIFT))));

  logic signed [XY_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  logic                   flip_r;

  always_comb begin
    if (!z_i[Z_W-1]) begin
      x_nxt = x_i - (y_i >>> SHIFT);
      y_nxt = y_i + (x_i >>> SHIFT);
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + (y_i >>> SHIFT);
      y_nxt = y_i - (x_i >>> SHIFT);
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      flip_r <= flip_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign flip_o = flip_r;

endmodule
`default_nettype wire

// ===== sv/hvd_sqrt_cell.sv =====
// one digit step of the bitwise integer square root
`default_nettype none
module hvd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hvd_pkg::SQ_W-1:0]   v_i,
  input  logic [hvd_pkg::SQ_W-1:0]   res_i,
  output logic [hvd_pkg::SQ_W-1:0]   v_o,
  output logic [hvd_pkg::SQ_W-1:0]   res_o
);
  import hvd_pkg::*;

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 1 - 2 * STEP);

  logic [SQ_W:0]   trial;
  logic            ge;
  logic [SQ_W-1:0] v_r, res_r, v_nxt, res_nxt;

  always_comb begin
    trial = {1'b0, res_i} + {1'b0, BIT};
    ge    = {1'b0, v_i} >= trial;
    if (ge) begin
      v_nxt   = v_i - trial[SQ_W-1:0];
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      v_nxt   = v_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
    end
  end

  assign v_o   = v_r;
  assign res_o = res_r;

endmodule
`default_nettype wire

// ===== sv/hvd_vec_cell.sv =====
// one vectoring-mode cordic stage for the arcsine
`default_nettype none
module hvd_vec_cell #(
  parameter int SHIFT = 0
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [hvd_pkg::VXY_W-1:0] x_i,
  input  logic signed [hvd_pkg::VXY_W-1:0] y_i,
  input  logic signed [hvd_pkg::VZ_W-1:0]  z_i,
  output logic signed [hvd_pkg::VXY_W-1:0] x_o,
  output logic signed [hvd_pkg::VXY_W-1:0] y_o,
  output logic signed [hvd_pkg::VZ_W-1:0]  z_o
);
  import hvd_pkg::*;

  localparam logic signed [VZ_W-1:0] ATAN = signed'(VZ_W'(atan_val(5'(SHIFT))));

  logic signed [VXY_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [VZ_W-1:0]  z_r, z_nxt;
  logic                    y_pos;

  always_comb begin
    y_pos = !y_i[VXY_W-1] && (|y_i);
    if (y_pos) begin
      x_nxt = x_i + (y_i >>> SHIFT);
      y_nxt = y_i - (x_i >>> SHIFT);
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - (y_i >>> SHIFT);
      y_nxt = y_i + (x_i >>> SHIFT);
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule
`default_nettype wire

// ===== sv/haversine_distance.sv =====
// top level: pipelined haversine great-circle distance
// throughput: one transaction per cycle; every stage is a register step of a single
// pipeline that advances whenever the output register is empty or being taken
// reset clears the stage valid bits and out_valid only; there is no clearing pass
`default_nettype none
module haversine_distance #(
  parameter int CORDIC_STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [29:0] in_first_latitude,
  input  logic signed [30:0] in_first_longitude,
  input  logic signed [29:0] in_second_latitude,
  input  logic signed [30:0] in_second_longitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        out_distance
);
  import hvd_pkg::*;

  localparam int NV = 43 + 2 * CORDIC_STAGES;

  logic          adv;
  logic [NV-1:0] vld_r;
  logic          out_valid_r;
  logic [30:0]   out_distance_r;

  // angle conversion
  logic signed [39:0]    n_c   [4];
  logic [MAG_W-1:0]      m_c   [4];
  logic [MAG_W-1:0]      m_r   [4];
  logic [3:0]            neg_r, neg2_r, neg3_r;
  logic [39:0]           p00_r [4];
  logic [39:0]           p01_r [4];
  logic [38:0]           p10_r [4];
  logic [38:0]           p11_r [4];
  logic [78:0]           psum_c [4];
  logic [33:0]           q_r   [4];
  logic [ANG_W-1:0]      ang_c [4];
  logic [3:0]            fold_c;
  logic signed [Z_W-1:0] z0_r  [4];
  logic [3:0]            flip0_r;

  // rotation chains
  logic signed [XY_W-1:0] rx [4][CORDIC_STAGES+1];
  logic signed [XY_W-1:0] ry [4][CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  rz [4][CORDIC_STAGES+1];
  logic                   rf [4][CORDIC_STAGES+1];

  // products and a
  logic signed [XY_W:0]    tv_c   [4];
  logic signed [XY_W:0]    tr_c   [4];
  logic signed [Q31_W-1:0] trig_c [4];
  logic signed [Q31_W-1:0] trig_r [4];
  logic signed [63:0]      sq_r, pt_r, pu_r, sq2_r, sq3_r, tu_r;
  logic signed [63:0]      pt_rnd_c, pu_rnd_c;
  logic signed [Q31_W-1:0] t_r, u_r;
  logic signed [64:0]      a_c;
  logic [SQ_W-1:0]         a_r, sa_r, sb_r;

  // square roots and arcsine
  logic [SQ_W-1:0]         sv_a [SQ_STEPS+1];
  logic [SQ_W-1:0]         sr_a [SQ_STEPS+1];
  logic [SQ_W-1:0]         sv_b [SQ_STEPS+1];
  logic [SQ_W-1:0]         sr_b [SQ_STEPS+1];
  logic signed [VXY_W-1:0] vx [CORDIC_STAGES+1];
  logic signed [VXY_W-1:0] vy [CORDIC_STAGES+1];
  logic signed [VZ_W-1:0]  vz [CORDIC_STAGES+1];

  // scaling
  logic [30:0]  zc_c, zc_r;
  logic [60:0]  prod_r;
  logic [61:0]  prod_rnd_c;
  logic [31:0]  d_c;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NV-2:0], in_valid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  // binary angles: round(v*64/45) for half differences, round(v*128/45) for latitudes
  always_comb begin
    n_c[0] = (40'(in_second_latitude) - 40'(in_first_latitude)) <<< 6;
    n_c[1] = (40'(in_second_longitude) - 40'(in_first_longitude)) <<< 6;
    n_c[2] = 40'(in_first_latitude) <<< 7;
    n_c[3] = 40'(in_second_latitude) <<< 7;
    for (int k = 0; k < 4; k++) begin
      m_c[k] = MAG_W'((n_c[k][39] ? -n_c[k] : n_c[k]) + 40'sd22);
      psum_c[k] = 79'(p00_r[k]) + ((79'(p01_r[k]) + 79'(p10_r[k])) << 20)
                + (79'(p11_r[k]) << 40);
      ang_c[k]  = neg3_r[k] ? -q_r[k][ANG_W-1:0] : q_r[k][ANG_W-1:0];
      fold_c[k] = ($signed(ang_c[k]) > 32'sd1073741824)
               || ($signed(ang_c[k]) < -32'sd1073741824);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        m_r[k]    <= m_c[k];
        neg_r[k]  <= n_c[k][39];
        p00_r[k]  <= m_r[k][19:0] * RECIP_LO;
        p01_r[k]  <= m_r[k][19:0] * RECIP_HI;
        p10_r[k]  <= m_r[k][MAG_W-1:20] * RECIP_LO;
        p11_r[k]  <= m_r[k][MAG_W-1:20] * RECIP_HI;
        neg2_r[k] <= neg_r[k];
        q_r[k]    <= psum_c[k][78:RECIP_SHIFT];
        neg3_r[k] <= neg2_r[k];
        z0_r[k]   <= Z_W'($signed(ang_c[k] ^ {fold_c[k], 31'd0}));
        flip0_r[k] <= fold_c[k];
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_rot
    assign rx[k][0] = INV_GAIN;
    assign ry[k][0] = '0;
    assign rz[k][0] = z0_r[k];
    assign rf[k][0] = flip0_r[k];
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      hvd_rot_cell #(.SHIFT(i)) u_cell (
        .clk    (clk),
        .en     (adv),
        .x_i    (rx[k][i]),
        .y_i    (ry[k][i]),
        .z_i    (rz[k][i]),
        .flip_i (rf[k][i]),
        .x_o    (rx[k][i+1]),
        .y_o    (ry[k][i+1]),
        .z_o    (rz[k][i+1]),
        .flip_o (rf[k][i+1])
      );
    end
  end

  // sines for the two differences, cosines for the two latitudes, rounded to q31
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tv_c[k] = (k < 2) ? (XY_W+1)'(ry[k][CORDIC_STAGES])
                        : (XY_W+1)'(rx[k][CORDIC_STAGES]);
      if (rf[k][CORDIC_STAGES]) tv_c[k] = -tv_c[k];
      tr_c[k] = (tv_c[k] + (XY_W+1)'(1)) >>> 1;
      if (tr_c[k] > (XY_W+1)'(Q31_MAX))
        trig_c[k] = Q31_MAX;
      else if (tr_c[k] < -(XY_W+1)'(Q31_MAX))
        trig_c[k] = -Q31_MAX;
      else
        trig_c[k] = tr_c[k][Q31_W-1:0];
    end
    pt_rnd_c = (pt_r + 64'sd1073741824) >>> 31;
    pu_rnd_c = (pu_r + 64'sd1073741824) >>> 31;
    a_c      = 65'(sq3_r) + 65'(tu_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) trig_r[k] <= trig_c[k];
      sq_r  <= trig_r[0] * trig_r[0];
      pt_r  <= trig_r[1] * trig_r[2];
      pu_r  <= trig_r[1] * trig_r[3];
      sq2_r <= sq_r;
      t_r   <= pt_rnd_c[Q31_W-1:0];
      u_r   <= pu_rnd_c[Q31_W-1:0];
      sq3_r <= sq2_r;
      tu_r  <= t_r * u_r;
      if (a_c[64])
        a_r <= '0;
      else if (a_c > 65'(ONE_Q62))
        a_r <= ONE_Q62;
      else
        a_r <= a_c[SQ_W-1:0];
      sa_r <= a_r;
      sb_r <= ONE_Q62 - a_r;
    end
  end

  assign sv_a[0] = sa_r;
  assign sr_a[0] = '0;
  assign sv_b[0] = sb_r;
  assign sr_b[0] = '0;

  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
    hvd_sqrt_cell #(.STEP(s)) u_root_a (
      .clk   (clk),
      .en    (adv),
      .v_i   (sv_a[s]),
      .res_i (sr_a[s]),
      .v_o   (sv_a[s+1]),
      .res_o (sr_a[s+1])
    );
    hvd_sqrt_cell #(.STEP(s)) u_root_b (
      .clk   (clk),
      .en    (adv),
      .v_i   (sv_b[s]),
      .res_i (sr_b[s]),
      .v_o   (sv_b[s+1]),
      .res_o (sr_b[s+1])
    );
  end

  // arcsine as the angle of (sqrt(1-a), sqrt(a))
  assign vx[0] = signed'(VXY_W'(sr_b[SQ_STEPS][RT_W-1:0]));
  assign vy[0] = signed'(VXY_W'(sr_a[SQ_STEPS][RT_W-1:0]));
  assign vz[0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    hvd_vec_cell #(.SHIFT(i)) u_cell (
      .clk (clk),
      .en  (adv),
      .x_i (vx[i]),
      .y_i (vy[i]),
      .z_i (vz[i]),
      .x_o (vx[i+1]),
      .y_o (vy[i+1]),
      .z_o (vz[i+1])
    );
  end

  always_comb begin
    if (vz[CORDIC_STAGES][VZ_W-1])
      zc_c = '0;
    else if (vz[CORDIC_STAGES] > signed'(QUARTER_TURN))
      zc_c = QUARTER_TURN[30:0];
    else
      zc_c = vz[CORDIC_STAGES][30:0];
    prod_rnd_c = 62'(prod_r) + 62'(64'd2147483648);
    d_c = 32'(zc_r) + 32'(prod_rnd_c >> 32);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zc_r   <= zc_c;
      prod_r <= zc_c * DIST_MULT_LO;
      out_distance_r <= (d_c > 32'(HALF_DIST)) ? HALF_DIST : d_c[30:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vld_r[NV-1]))
    else $error("result appeared without an item in the last stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> vld_r == $past(vld_r))
    else $error("pipeline moved while the output was stalled");

  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_distance_r <= HALF_DIST)
    else $error("distance beyond half circumference");

endmodule
`default_nettype wire
